[design/slfw_pkg.sv]
package slfw_pkg;

  localparam int ROM_DEPTH = 42;
  localparam int PC_W      = $clog2(ROM_DEPTH);

  typedef enum logic [1:0] {
    REQ_CMD  = 2'd0,
    REQ_NIB  = 2'd1,
    REQ_BST  = 2'd2,
    REQ_BYTE = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    SRC_ZERO = 2'd0,
    SRC_ONE  = 2'd1,
    SRC_ADDR = 2'd2,
    SRC_DATA = 2'd3
  } src_t;

  typedef enum logic [1:0] {
    CL_NEVER   = 2'd0,
    CL_ALWAYS  = 2'd1,
    CL_IF_LAST = 2'd2
  } close_t;

  typedef struct packed {
    src_t       src;
    logic [2:0] sel;
    logic       eop;
    close_t     close;
    logic       open_burst;
    logic       close_burst;
  } ucode_t;

  typedef struct packed {
    logic   load;
    logic   emit;
    ucode_t word;
  } dp_ctl_t;

  localparam logic [PC_W-1:0] CMD_ENTRY  = PC_W'(0);
  localparam logic [PC_W-1:0] NIB_ENTRY  = PC_W'(12);
  localparam logic [PC_W-1:0] BST_ENTRY  = PC_W'(25);
  localparam logic [PC_W-1:0] BYTE_ENTRY = PC_W'(34);

  function automatic ucode_t stp(src_t src, logic [2:0] sel);
    ucode_t w;
    w.src         = src;
    w.sel         = sel;
    w.eop         = 1'b0;
    w.close       = CL_NEVER;
    w.open_burst  = 1'b0;
    w.close_burst = 1'b0;
    return w;
  endfunction

  function automatic ucode_t fin(src_t src, logic [2:0] sel, close_t close,
                                 logic ob, logic cb);
    ucode_t w;
    w.src         = src;
    w.sel         = sel;
    w.eop         = 1'b1;
    w.close       = close;
    w.open_burst  = ob;
    w.close_burst = cb;
    return w;
  endfunction

  localparam ucode_t ROM [ROM_DEPTH] = '{
    // command: 1 0 0, code msb first, 0
    stp(SRC_ONE, 3'd0), stp(SRC_ZERO, 3'd0), stp(SRC_ZERO, 3'd0),
    stp(SRC_DATA, 3'd7), stp(SRC_DATA, 3'd6), stp(SRC_DATA, 3'd5), stp(SRC_DATA, 3'd4),
    stp(SRC_DATA, 3'd3), stp(SRC_DATA, 3'd2), stp(SRC_DATA, 3'd1), stp(SRC_DATA, 3'd0),
    fin(SRC_ZERO, 3'd0, CL_ALWAYS, 1'b0, 1'b0),
    // nibble write: 1 0 1, address msb first, nibble lsb first
    stp(SRC_ONE, 3'd0), stp(SRC_ZERO, 3'd0), stp(SRC_ONE, 3'd0),
    stp(SRC_ADDR, 3'd5), stp(SRC_ADDR, 3'd4), stp(SRC_ADDR, 3'd3),
    stp(SRC_ADDR, 3'd2), stp(SRC_ADDR, 3'd1), stp(SRC_ADDR, 3'd0),
    stp(SRC_DATA, 3'd0), stp(SRC_DATA, 3'd1), stp(SRC_DATA, 3'd2),
    fin(SRC_DATA, 3'd3, CL_ALWAYS, 1'b0, 1'b0),
    // burst start: 1 0 1, address, chip select stays low
    stp(SRC_ONE, 3'd0), stp(SRC_ZERO, 3'd0), stp(SRC_ONE, 3'd0),
    stp(SRC_ADDR, 3'd5), stp(SRC_ADDR, 3'd4), stp(SRC_ADDR, 3'd3),
    stp(SRC_ADDR, 3'd2), stp(SRC_ADDR, 3'd1),
    fin(SRC_ADDR, 3'd0, CL_NEVER, 1'b1, 1'b0),
    // burst byte: lsb first
    stp(SRC_DATA, 3'd0), stp(SRC_DATA, 3'd1), stp(SRC_DATA, 3'd2), stp(SRC_DATA, 3'd3),
    stp(SRC_DATA, 3'd4), stp(SRC_DATA, 3'd5), stp(SRC_DATA, 3'd6),
    fin(SRC_DATA, 3'd7, CL_IF_LAST, 1'b0, 1'b1)
  };

  function automatic logic [PC_W-1:0] entry_of(req_t kind);
    logic [PC_W-1:0] e;
    unique case (kind)
      REQ_CMD:  e = CMD_ENTRY;
      REQ_NIB:  e = NIB_ENTRY;
      REQ_BST:  e = BST_ENTRY;
      REQ_BYTE: e = BYTE_ENTRY;
      default:  e = CMD_ENTRY;
    endcase
    return e;
  endfunction

endpackage

[design/slfw_if.sv]
interface slfw_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [5:0] address;
  logic [7:0] data;
  logic       burst_last;

  modport source (output valid, req_type, address, data, burst_last, input ready);
  modport sink   (input valid, req_type, address, data, burst_last, output ready);
endinterface

interface slfw_res_if;
  logic valid;
  logic ready;
  logic data_bit;
  logic frame_end;
  logic last;

  modport source (output valid, data_bit, frame_end, last, input ready);
  modport sink   (input valid, data_bit, frame_end, last, output ready);
endinterface

[design/slfw_seq.sv]
module slfw_seq (
  input  logic                clk,
  input  logic                rst,
  slfw_req_if.sink            req,
  input  logic                room,
  input  logic                lastb,
  output slfw_pkg::dp_ctl_t   ctl
);

  logic                        busy, busy_next;
  logic [slfw_pkg::PC_W-1:0]   pc, pc_next;
  logic                        burst_open, burst_open_next;
  slfw_pkg::ucode_t            word;
  slfw_pkg::req_t              kind;
  logic                        accept, start, go;

  assign req.ready = !busy;

  always_comb begin
    kind            = slfw_pkg::req_t'(req.req_type);
    word            = slfw_pkg::ROM[pc];
    accept          = req.valid && req.ready;
    start           = accept && ((kind == slfw_pkg::REQ_BYTE) == burst_open);
    go              = busy && room;
    busy_next       = busy;
    pc_next         = pc;
    burst_open_next = burst_open;
    priority if (start) begin
      busy_next = 1'b1;
      pc_next   = slfw_pkg::entry_of(kind);
    end else if (go) begin
      if (word.eop) begin
        busy_next = 1'b0;
        if (word.open_burst) burst_open_next = 1'b1;
        if (word.close_burst && lastb) burst_open_next = 1'b0;
      end else begin
        pc_next = pc + slfw_pkg::PC_W'(1);
      end
    end
    ctl.load = accept;
    ctl.emit = go;
    ctl.word = word;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      pc         <= '0;
      burst_open <= 1'b0;
    end else begin
      busy       <= busy_next;
      pc         <= pc_next;
      burst_open <= burst_open_next;
    end
  end

  a_pc_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> (pc < slfw_pkg::PC_W'(slfw_pkg::ROM_DEPTH)))
    else $error("step counter past end of program");

  a_eop_idle: assert property (@(posedge clk) disable iff (rst)
    (go && word.eop) |=> !busy)
    else $error("sequencer still busy after end of program");

  a_burst_change: assert property (@(posedge clk) disable iff (rst)
    (burst_open != $past(burst_open)) |-> $past(go && word.eop))
    else $error("burst state changed outside end of program");

endmodule

[design/slfw_dp.sv]
module slfw_dp (
  input  logic               clk,
  input  logic               rst,
  input  slfw_pkg::dp_ctl_t  ctl,
  input  logic [5:0]         address,
  input  logic [7:0]         data,
  input  logic               burst_last,
  output logic               room,
  output logic               lastb,
  slfw_res_if.source         res
);

  logic [7:0] addr_q;
  logic [7:0] data_q;
  logic       last_q;
  logic       bit_val;
  logic       fe_val;
  logic       out_valid;
  logic       out_bit;
  logic       out_fe;
  logic       out_last;

  assign room      = !out_valid || res.ready;
  assign lastb     = last_q;
  assign res.valid     = out_valid;
  assign res.data_bit  = out_bit;
  assign res.frame_end = out_fe;
  assign res.last      = out_last;

  always_comb begin
    unique case (ctl.word.src)
      slfw_pkg::SRC_ZERO: bit_val = 1'b0;
      slfw_pkg::SRC_ONE:  bit_val = 1'b1;
      slfw_pkg::SRC_ADDR: bit_val = addr_q[ctl.word.sel];
      slfw_pkg::SRC_DATA: bit_val = data_q[ctl.word.sel];
      default:            bit_val = 1'b0;
    endcase
    fe_val = ctl.word.eop && ((ctl.word.close == slfw_pkg::CL_ALWAYS) ||
             ((ctl.word.close == slfw_pkg::CL_IF_LAST) && last_q));
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      addr_q <= {2'b00, address};
      data_q <= data;
      last_q <= burst_last;
    end
    if (ctl.emit) begin
      out_bit  <= bit_val;
      out_fe   <= fe_val;
      out_last <= ctl.word.eop;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.emit) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  a_fe_last: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!out_fe || out_last))
    else $error("frame end on a word that is not the last of its request");

endmodule

[design/segment_lcd_serial_frame_writer.sv]
// Serial frame writer for a three-wire segment LCD controller.
// req channel: one word per request (command, nibble write, burst start,
// burst byte). res channel: one word per data-pin bit, in send order, with
// frame_end set where chip select is released and last on the final bit of
// the request.
// Requests that do not fit the burst state (a burst byte with no burst open,
// anything else inside a burst) are taken and dropped with no output.
// A request is taken while the sequencer is idle; after acceptance the
// sequencer steps through its program, one bit per cycle into the output
// register while the receiver has room. A request gives n bits, n being
// 12 (command), 13 (nibble write), 9 (burst start) or 8 (burst byte); the
// figure is set by the microcode sequencer stepping one control word per bit.
// When the receiver stalls, the output register holds its word and the
// sequencer halts on the current step; req.ready stays low until the
// program ends.
// Reset (synchronous, rst high) empties the output register, idles the
// sequencer and closes any open burst.
module segment_lcd_serial_frame_writer (
  input logic         clk,
  input logic         rst,
  slfw_req_if.sink    req,
  slfw_res_if.source  res
);

  slfw_pkg::dp_ctl_t ctl;
  logic              room;
  logic              lastb;

  slfw_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .req   (req),
    .room  (room),
    .lastb (lastb),
    .ctl   (ctl)
  );

  slfw_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .address    (req.address),
    .data       (req.data),
    .burst_last (req.burst_last),
    .room       (room),
    .lastb      (lastb),
    .res        (res)
  );

endmodule
